>>> hw/rtl/cpt_pkg.sv
// Shared constants and region codes for the closest-point-on-triangle core.
package cpt_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int WEIGHT_BITS  = 16;
   localparam int REGION_WIDTH = 3;

   typedef enum logic [REGION_WIDTH-1:0] {
      REGION_A    = 3'd0,
      REGION_B    = 3'd1,
      REGION_AB   = 3'd2,
      REGION_C    = 3'd3,
      REGION_AC   = 3'd4,
      REGION_BC   = 3'd5,
      REGION_FACE = 3'd6
   } region_type;

endpackage

>>> hw/rtl/cpt_if.sv
// Valid/ready channel interfaces for the query and result transactions.
interface cpt_req_if #(parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] ax, ay, az;
   logic signed [COORD_WIDTH-1:0] bx, by_coord, bz;
   logic signed [COORD_WIDTH-1:0] cx, cy, cz;
   logic signed [COORD_WIDTH-1:0] px, py, pz;

   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                   input ready);
   modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                 output ready);
endinterface

interface cpt_rsp_if #(parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH);
   logic                                 valid;
   logic                                 ready;
   logic signed [COORD_WIDTH-1:0]        qx, qy, qz;
   logic [cpt_pkg::REGION_WIDTH-1:0]     region;
   logic                                 degenerate;

   modport source (output valid, qx, qy, qz, region, degenerate, input ready);
   modport sink (input valid, qx, qy, qz, region, degenerate, output ready);
endinterface

>>> hw/rtl/cpt_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, fraction-scaled.
module cpt_div #(
   parameter int NUM_W = 32,
   parameter int QUO_W = 17
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   output logic [QUO_W-1:0] quo
);
   localparam int RW = NUM_W + QUO_W - 1;

   logic [RW-1:0]    rem_ff [QUO_W];
   logic [NUM_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [RW-1:0]    rem_cur;
      logic [RW-1:0]    sub_cur;
      logic [NUM_W-1:0] den_cur;
      logic [QUO_W-1:0] quo_cur;

      if (i == 0) begin : g_first
         assign rem_cur = RW'(num) << (QUO_W - 1);
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign quo_cur = quo_ff[i-1];
      end

      assign sub_cur = RW'(den_cur) << (QUO_W - 1 - i);

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[i] <= den_cur;
            if (rem_cur >= sub_cur) begin
               rem_ff[i] <= rem_cur - sub_cur;
               quo_ff[i] <= quo_cur | (QUO_W'(1) << (QUO_W - 1 - i));
            end else begin
               rem_ff[i] <= rem_cur;
               quo_ff[i] <= quo_cur;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

>>> hw/rtl/closest_point_on_triangle_core.sv
// The core accepts one transaction per clock while the result side keeps taking transactions;
// a stalled result holds the whole pipeline in place. The depth is set by the two restoring
// dividers, which resolve one weight bit per stage, and by the dot-product and cross-term
// multipliers, which are split into registered partial products.
module closest_point_on_triangle_core #(
   parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH,
   parameter int WEIGHT_BITS = cpt_pkg::WEIGHT_BITS
) (
   input logic         clock,
   input logic         reset,
   cpt_req_if.sink     req_bus,
   cpt_rsp_if.source   rsp_bus
);
   import cpt_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DF  = W + 1;
   localparam int PW  = 2 * DF;
   localparam int DW  = PW + 2;
   localparam int LK  = DW / 2;
   localparam int HK  = DW - LK;
   localparam int PLW = LK + 1 + HK;
   localparam int BW  = 2 * DW;
   localparam int VW  = BW + 1;
   localparam int MW  = VW + 2;
   localparam int QW  = WEIGHT_BITS + 1;
   localparam int WW  = QW + 1;
   localparam int PRW = WW + DF;
   localparam int SW  = PRW + 2;
   localparam int NST = QW + 12;

   localparam logic signed [SW-1:0] QMAX = (SW'(1) <<< (W - 1)) - SW'(1);
   localparam logic signed [SW-1:0] QMIN = -QMAX - SW'(1);

   typedef logic signed [W-1:0]  coord_type;
   typedef logic signed [DW-1:0] dot_type;
   typedef struct packed { coord_type x, y, z; } cvec_type;
   typedef struct packed { logic signed [DF-1:0] x, y, z; } dvec_type;
   typedef struct packed { logic signed [PW-1:0] x, y, z; } prod3_type;
   typedef struct packed { logic signed [PRW-1:0] x, y, z; } pvec_type;
   typedef struct packed { logic signed [SW-1:0] x, y, z; } svec_type;
   typedef struct packed { cvec_type a, b, c; dvec_type ab, ac, bc; } geo_type;
   typedef struct packed { dvec_type ap, bp, cp; } pt_type;
   typedef struct packed {
      logic [2*LK-1:0]          ll;
      logic signed [PLW-1:0]    lh;
      logic signed [PLW-1:0]    hl;
      logic signed [2*HK-1:0]   hh;
   } part_type;
   typedef struct packed {
      dot_type               d1, d2, d3, d6;
      logic signed [DW:0]    n_ab, n_ac, e1, e2;
      logic signed [DW+1:0]  e12;
   } edge_type;
   typedef struct packed {
      region_type            region;
      logic                  face;
      logic                  w0_on;
      logic                  w1_on;
      logic signed [MW-1:0]  num0, div0, num1, div1;
      cvec_type              base;
      dvec_type              u, v;
   } sel_type;
   typedef struct packed {
      region_type region;
      logic       degen;
      logic       on0, on1;
      logic       neg0, neg1;
      cvec_type   base;
      dvec_type   u, v;
   } side_type;
   typedef struct packed {
      logic [MW-1:0] num0, den0, num1, den1;
      side_type      side;
   } div_in_type;
   typedef struct packed {
      region_type           region;
      logic                 degen;
      cvec_type             base;
      dvec_type             u, v;
      logic signed [WW-1:0] w0, w1;
   } wgt_type;
   typedef struct packed {
      region_type region;
      logic       degen;
      cvec_type   base;
      pvec_type   p0, p1;
   } mul_type;
   typedef struct packed {
      region_type region;
      logic       degen;
      cvec_type   base;
      svec_type   t;
   } off_type;
   typedef struct packed {
      region_type region;
      logic       degen;
      cvec_type   q;
   } out_type;

   function automatic dvec_type vdiff(cvec_type p, cvec_type q);
      dvec_type r;
      r.x = DF'(p.x) - DF'(q.x);
      r.y = DF'(p.y) - DF'(q.y);
      r.z = DF'(p.z) - DF'(q.z);
      return r;
   endfunction

   function automatic prod3_type vmul(dvec_type u, dvec_type v);
      prod3_type r;
      r.x = PW'(u.x) * PW'(v.x);
      r.y = PW'(u.y) * PW'(v.y);
      r.z = PW'(u.z) * PW'(v.z);
      return r;
   endfunction

   function automatic dot_type dsum(prod3_type p);
      return DW'(p.x) + DW'(p.y) + DW'(p.z);
   endfunction

   function automatic part_type pmul(dot_type a, dot_type b);
      part_type             r;
      logic [LK-1:0]        al, bl;
      logic signed [HK-1:0] ah, bh;
      al = a[LK-1:0];
      bl = b[LK-1:0];
      ah = a[DW-1:LK];
      bh = b[DW-1:LK];
      r.ll = (2*LK)'(al) * (2*LK)'(bl);
      r.lh = PLW'(signed'({1'b0, al})) * PLW'(bh);
      r.hl = PLW'(ah) * PLW'(signed'({1'b0, bl}));
      r.hh = (2*HK)'(ah) * (2*HK)'(bh);
      return r;
   endfunction

   function automatic logic signed [BW-1:0] pjoin(part_type p);
      logic signed [BW-1:0] r;
      r = (BW'(p.hh) << (2 * LK)) + ((BW'(p.lh) + BW'(p.hl)) << LK) + BW'(p.ll);
      return r;
   endfunction

   function automatic logic [MW-1:0] mag(logic signed [MW-1:0] x);
      return x[MW-1] ? MW'(-x) : MW'(x);
   endfunction

   function automatic logic signed [WW-1:0] sweight(logic [QW-1:0] q, logic on, logic neg);
      logic signed [WW-1:0] s;
      s = signed'(WW'(q));
      if (!on) begin
         return '0;
      end
      return neg ? -s : s;
   endfunction

   function automatic pvec_type wmul(logic signed [WW-1:0] w, dvec_type u);
      pvec_type r;
      r.x = PRW'(w) * PRW'(u.x);
      r.y = PRW'(w) * PRW'(u.y);
      r.z = PRW'(w) * PRW'(u.z);
      return r;
   endfunction

   function automatic logic signed [SW-1:0] wsum(logic signed [PRW-1:0] a,
                                                 logic signed [PRW-1:0] b);
      logic signed [SW-1:0] s;
      s = SW'(a) + SW'(b);
      return s >>> WEIGHT_BITS;
   endfunction

   function automatic coord_type sat(coord_type base, logic signed [SW-1:0] t);
      logic signed [SW-1:0] s;
      s = SW'(base) + t;
      if (s > QMAX) begin
         s = QMAX;
      end else if (s < QMIN) begin
         s = QMIN;
      end
      return s[W-1:0];
   endfunction

   logic [NST-1:0]       vld_ff;
   logic                 en;
   geo_type              geo_in;
   pt_type               pt_in;
   geo_type              geo_ff [6];
   pt_type               pt_ff;
   prod3_type            pr_ff [6];
   dot_type              d_ff [6];
   part_type             mp_ff [6];
   edge_type             ed_in;
   edge_type             ed_ff [3];
   logic signed [BW-1:0] m_ff [6];
   logic signed [VW-1:0] vc_ff, vb_ff, va_ff;
   sel_type              sel_in;
   sel_type              sel_ff;
   div_in_type           dv_in;
   div_in_type           dv_ff;
   side_type             sd_ff [QW];
   logic [QW-1:0]        q0, q1;
   wgt_type              wg_ff;
   mul_type              mu_ff;
   off_type              of_ff;
   out_type              out_ff;

   assign en            = !vld_ff[NST-1] || rsp_bus.ready;
   assign req_bus.ready = en;

   always_comb begin
      geo_in.a  = '{x: W'(req_bus.ax), y: W'(req_bus.ay), z: W'(req_bus.az)};
      geo_in.b  = '{x: W'(req_bus.bx), y: W'(req_bus.by_coord), z: W'(req_bus.bz)};
      geo_in.c  = '{x: W'(req_bus.cx), y: W'(req_bus.cy), z: W'(req_bus.cz)};
      geo_in.ab = vdiff(geo_in.b, geo_in.a);
      geo_in.ac = vdiff(geo_in.c, geo_in.a);
      geo_in.bc = vdiff(geo_in.c, geo_in.b);
      pt_in.ap  = vdiff('{x: W'(req_bus.px), y: W'(req_bus.py), z: W'(req_bus.pz)}, geo_in.a);
      pt_in.bp  = vdiff('{x: W'(req_bus.px), y: W'(req_bus.py), z: W'(req_bus.pz)}, geo_in.b);
      pt_in.cp  = vdiff('{x: W'(req_bus.px), y: W'(req_bus.py), z: W'(req_bus.pz)}, geo_in.c);
   end

   always_comb begin
      ed_in.d1   = d_ff[0];
      ed_in.d2   = d_ff[1];
      ed_in.d3   = d_ff[2];
      ed_in.d6   = d_ff[5];
      ed_in.n_ab = (DW+1)'(d_ff[0]) - (DW+1)'(d_ff[2]);
      ed_in.n_ac = (DW+1)'(d_ff[1]) - (DW+1)'(d_ff[5]);
      ed_in.e1   = (DW+1)'(d_ff[3]) - (DW+1)'(d_ff[2]);
      ed_in.e2   = (DW+1)'(d_ff[4]) - (DW+1)'(d_ff[5]);
      ed_in.e12  = (DW+2)'(d_ff[3]) - (DW+2)'(d_ff[2]) + (DW+2)'(d_ff[4])
                   - (DW+2)'(d_ff[5]);
   end

   // Voronoi classification in priority order, then the divider operands for the region.
   always_comb begin
      logic     le_d1, le_d2, ge_d1, ge_d2, le_d3, ge_d3, le_d6, ge_d6;
      logic     le_e1, ge_e1, le_e2, ge_e2, le_va, le_vb, le_vc;
      edge_type ed;
      geo_type  geo;
      logic signed [MW-1:0] den;
      ed    = ed_ff[2];
      geo   = geo_ff[5];
      le_d1 = ed.d1[DW-1] || (ed.d1 == '0);
      le_d2 = ed.d2[DW-1] || (ed.d2 == '0);
      le_d3 = ed.d3[DW-1] || (ed.d3 == '0);
      le_d6 = ed.d6[DW-1] || (ed.d6 == '0);
      ge_d1 = !ed.d1[DW-1];
      ge_d2 = !ed.d2[DW-1];
      ge_d3 = !ed.d3[DW-1];
      ge_d6 = !ed.d6[DW-1];
      le_e1 = ed.e1[DW] || (ed.e1 == '0);
      le_e2 = ed.e2[DW] || (ed.e2 == '0);
      ge_e1 = !ed.e1[DW];
      ge_e2 = !ed.e2[DW];
      le_va = va_ff[VW-1] || (va_ff == '0);
      le_vb = vb_ff[VW-1] || (vb_ff == '0);
      le_vc = vc_ff[VW-1] || (vc_ff == '0);
      den   = MW'(va_ff) + MW'(vb_ff) + MW'(vc_ff);

      sel_in        = '0;
      sel_in.region = REGION_FACE;
      sel_in.face   = 1'b1;
      sel_in.w0_on  = 1'b1;
      sel_in.w1_on  = 1'b1;
      sel_in.num0   = MW'(vb_ff);
      sel_in.div0   = den;
      sel_in.num1   = MW'(vc_ff);
      sel_in.div1   = den;
      sel_in.base   = geo.a;
      sel_in.u      = geo.ab;
      sel_in.v      = geo.ac;
      if (le_d1 && le_d2) begin
         sel_in.region = REGION_A;
         sel_in.face   = 1'b0;
         sel_in.w0_on  = 1'b0;
         sel_in.w1_on  = 1'b0;
      end else if (ge_d3 && le_e1) begin
         sel_in.region = REGION_B;
         sel_in.face   = 1'b0;
         sel_in.w0_on  = 1'b0;
         sel_in.w1_on  = 1'b0;
         sel_in.base   = geo.b;
      end else if (le_vc && ge_d1 && le_d3) begin
         sel_in.region = REGION_AB;
         sel_in.face   = 1'b0;
         sel_in.w1_on  = 1'b0;
         sel_in.num0   = MW'(ed.d1);
         sel_in.div0   = MW'(ed.n_ab);
      end else if (ge_d6 && le_e2) begin
         sel_in.region = REGION_C;
         sel_in.face   = 1'b0;
         sel_in.w0_on  = 1'b0;
         sel_in.w1_on  = 1'b0;
         sel_in.base   = geo.c;
      end else if (le_vb && ge_d2 && le_d6) begin
         sel_in.region = REGION_AC;
         sel_in.face   = 1'b0;
         sel_in.w1_on  = 1'b0;
         sel_in.num0   = MW'(ed.d2);
         sel_in.div0   = MW'(ed.n_ac);
         sel_in.u      = geo.ac;
      end else if (le_va && ge_e1 && ge_e2) begin
         sel_in.region = REGION_BC;
         sel_in.face   = 1'b0;
         sel_in.w1_on  = 1'b0;
         sel_in.num0   = MW'(ed.e1);
         sel_in.div0   = MW'(ed.e12);
         sel_in.base   = geo.b;
         sel_in.u      = geo.bc;
      end
   end

   always_comb begin
      logic dz0, dz1;
      dz0 = (sel_ff.div0 == '0);
      dz1 = (sel_ff.div1 == '0);
      dv_in.num0        = mag(sel_ff.num0);
      dv_in.den0        = mag(sel_ff.div0);
      dv_in.num1        = mag(sel_ff.num1);
      dv_in.den1        = mag(sel_ff.div1);
      dv_in.side.region = sel_ff.region;
      dv_in.side.degen  = sel_ff.face && dz0;
      dv_in.side.on0    = sel_ff.w0_on && !dz0;
      dv_in.side.on1    = sel_ff.w1_on && !dz1;
      dv_in.side.neg0   = sel_ff.num0[MW-1] ^ sel_ff.div0[MW-1];
      dv_in.side.neg1   = sel_ff.num1[MW-1] ^ sel_ff.div1[MW-1];
      dv_in.side.base   = sel_ff.base;
      dv_in.side.u      = sel_ff.u;
      dv_in.side.v      = sel_ff.v;
   end

   cpt_div #(.NUM_W(MW), .QUO_W(QW)) u_div0 (
      .clock (clock),
      .en    (en),
      .num   (dv_ff.num0),
      .den   (dv_ff.den0),
      .quo   (q0)
   );

   cpt_div #(.NUM_W(MW), .QUO_W(QW)) u_div1 (
      .clock (clock),
      .en    (en),
      .num   (dv_ff.num1),
      .den   (dv_ff.den1),
      .quo   (q1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geo_ff[0] <= geo_in;
         for (int i = 1; i < 6; i++) begin
            geo_ff[i] <= geo_ff[i-1];
         end
         pt_ff    <= pt_in;
         pr_ff[0] <= vmul(geo_ff[0].ab, pt_ff.ap);
         pr_ff[1] <= vmul(geo_ff[0].ac, pt_ff.ap);
         pr_ff[2] <= vmul(geo_ff[0].ab, pt_ff.bp);
         pr_ff[3] <= vmul(geo_ff[0].ac, pt_ff.bp);
         pr_ff[4] <= vmul(geo_ff[0].ab, pt_ff.cp);
         pr_ff[5] <= vmul(geo_ff[0].ac, pt_ff.cp);
         for (int i = 0; i < 6; i++) begin
            d_ff[i] <= dsum(pr_ff[i]);
         end
         mp_ff[0] <= pmul(d_ff[0], d_ff[3]);
         mp_ff[1] <= pmul(d_ff[2], d_ff[1]);
         mp_ff[2] <= pmul(d_ff[4], d_ff[1]);
         mp_ff[3] <= pmul(d_ff[0], d_ff[5]);
         mp_ff[4] <= pmul(d_ff[2], d_ff[5]);
         mp_ff[5] <= pmul(d_ff[4], d_ff[3]);
         ed_ff[0] <= ed_in;
         ed_ff[1] <= ed_ff[0];
         ed_ff[2] <= ed_ff[1];
         for (int i = 0; i < 6; i++) begin
            m_ff[i] <= pjoin(mp_ff[i]);
         end
         vc_ff    <= VW'(m_ff[0]) - VW'(m_ff[1]);
         vb_ff    <= VW'(m_ff[2]) - VW'(m_ff[3]);
         va_ff    <= VW'(m_ff[4]) - VW'(m_ff[5]);
         sel_ff   <= sel_in;
         dv_ff    <= dv_in;
         sd_ff[0] <= dv_ff.side;
         for (int i = 1; i < QW; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
         wg_ff.region <= sd_ff[QW-1].region;
         wg_ff.degen  <= sd_ff[QW-1].degen;
         wg_ff.base   <= sd_ff[QW-1].base;
         wg_ff.u      <= sd_ff[QW-1].u;
         wg_ff.v      <= sd_ff[QW-1].v;
         wg_ff.w0     <= sweight(q0, sd_ff[QW-1].on0, sd_ff[QW-1].neg0);
         wg_ff.w1     <= sweight(q1, sd_ff[QW-1].on1, sd_ff[QW-1].neg1);
         mu_ff.region <= wg_ff.region;
         mu_ff.degen  <= wg_ff.degen;
         mu_ff.base   <= wg_ff.base;
         mu_ff.p0     <= wmul(wg_ff.w0, wg_ff.u);
         mu_ff.p1     <= wmul(wg_ff.w1, wg_ff.v);
         of_ff.region <= mu_ff.region;
         of_ff.degen  <= mu_ff.degen;
         of_ff.base   <= mu_ff.base;
         of_ff.t.x    <= wsum(mu_ff.p0.x, mu_ff.p1.x);
         of_ff.t.y    <= wsum(mu_ff.p0.y, mu_ff.p1.y);
         of_ff.t.z    <= wsum(mu_ff.p0.z, mu_ff.p1.z);
         out_ff.region <= of_ff.region;
         out_ff.degen  <= of_ff.degen;
         out_ff.q.x    <= sat(of_ff.base.x, of_ff.t.x);
         out_ff.q.y    <= sat(of_ff.base.y, of_ff.t.y);
         out_ff.q.z    <= sat(of_ff.base.z, of_ff.t.z);
      end
   end

   assign rsp_bus.valid      = vld_ff[NST-1];
   assign rsp_bus.qx         = out_ff.q.x;
   assign rsp_bus.qy         = out_ff.q.y;
   assign rsp_bus.qz         = out_ff.q.z;
   assign rsp_bus.region     = out_ff.region;
   assign rsp_bus.degenerate = out_ff.degen;

   // A flagged degenerate result only comes out of the face case.
   a_degen_face: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.degenerate |-> rsp_bus.region == REGION_FACE)
      else $error("degenerate flag outside the face region");

   // The barycentric weight sum is a squared norm and is never negative.
   a_den_sign: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] && sel_ff.face |-> !sel_ff.div0[MW-1])
      else $error("negative face weight sum");

   // The first weight in use lies within one, so the divider keeps enough quotient bits.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QW+7] && sd_ff[QW-1].on0 |-> q0 <= (QW'(1) << WEIGHT_BITS))
      else $error("edge or face weight above one");

   // While the result side stalls, no transaction moves along the pipeline.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline advanced during a stall");

endmodule

>>> test/closest_point_on_triangle_checker.sv
// Checker that predicts each closest-point result and compares it with the core's output.
`timescale 1ns / 100ps

module closest_point_on_triangle_checker (
   input  logic clock,
   input  logic reset,
   cpt_req_if   req_mon,
   cpt_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count
);
   import cpt_pkg::*;

   typedef logic signed [255:0]           wide_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct {
      coord_type  qx, qy, qz;
      region_type region;
      logic       degenerate;
   } nearest_type;

   nearest_type nearest_queue[$];

   function automatic wide_type widen(input coord_type v);
      return {{(256 - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   function automatic wide_type dot3(input wide_type u[3], input wide_type v[3]);
      return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
   endfunction

   function automatic wide_type ratio(input wide_type num, input wide_type den);
      if (den == 0) return '0;
      return (num <<< WEIGHT_BITS) / den;
   endfunction

   function automatic coord_type clamp(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic nearest_type find_nearest(input coord_type c[12]);
      wide_type    a[3], b[3], cc[3], p[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3], q[3];
      wide_type    d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, s, t;
      wide_type    base[3], u[3];
      nearest_type r;
      bit          blend;
      for (int i = 0; i < 3; i++) begin
         a[i]  = widen(c[i]);
         b[i]  = widen(c[3 + i]);
         cc[i] = widen(c[6 + i]);
         p[i]  = widen(c[9 + i]);
         ab[i] = b[i] - a[i];
         ac[i] = cc[i] - a[i];
         bc[i] = cc[i] - b[i];
         ap[i] = p[i] - a[i];
         bp[i] = p[i] - b[i];
         cp[i] = p[i] - cc[i];
      end
      d1 = dot3(ab, ap);
      d2 = dot3(ac, ap);
      d3 = dot3(ab, bp);
      d4 = dot3(ac, bp);
      d5 = dot3(ab, cp);
      d6 = dot3(ac, cp);
      vc = d1 * d4 - d3 * d2;
      vb = d5 * d2 - d1 * d6;
      va = d3 * d6 - d5 * d4;
      e1 = d4 - d3;
      e2 = d5 - d6;
      r.degenerate = 1'b0;
      blend = 1'b1;
      s = '0;
      t = '0;
      base = a;
      u = ab;
      if (d1 <= 0 && d2 <= 0) begin
         r.region = REGION_A;
         blend = 1'b0;
         q = a;
      end else if (d3 >= 0 && e1 <= 0) begin
         r.region = REGION_B;
         blend = 1'b0;
         q = b;
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
         r.region = REGION_AB;
         s = ratio(d1, d1 - d3);
      end else if (d6 >= 0 && e2 <= 0) begin
         r.region = REGION_C;
         blend = 1'b0;
         q = cc;
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
         r.region = REGION_AC;
         t = ratio(d2, d2 - d6);
      end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
         r.region = REGION_BC;
         base = b;
         u = bc;
         s = ratio(e1, e1 + e2);
      end else begin
         r.region = REGION_FACE;
         if (va + vb + vc == 0) begin
            r.degenerate = 1'b1;
            blend = 1'b0;
            q = a;
         end else begin
            s = ratio(vb, va + vb + vc);
            t = ratio(vc, va + vb + vc);
         end
      end
      if (blend)
         for (int i = 0; i < 3; i++)
            q[i] = base[i] + ((s * u[i] + t * ac[i]) >>> WEIGHT_BITS);
      r.qx = clamp(q[0]);
      r.qy = clamp(q[1]);
      r.qz = clamp(q[2]);
      return r;
   endfunction

   assign pending_count = nearest_queue.size();

   always @(posedge clock) begin
      coord_type   query[12];
      nearest_type want;
      int          errs;
      errs = 0;
      if (reset) begin
         error_count <= 0;
         nearest_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            query = '{req_mon.ax, req_mon.ay, req_mon.az, req_mon.bx, req_mon.by_coord,
                      req_mon.bz, req_mon.cx, req_mon.cy, req_mon.cz, req_mon.px,
                      req_mon.py, req_mon.pz};
            nearest_queue.push_back(find_nearest(query));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (nearest_queue.size() == 0) begin
               $error("Result transaction arrived with no query outstanding.");
               errs++;
            end else begin
               want = nearest_queue.pop_front();
               if (rsp_mon.qx !== want.qx) begin
                  $error("qx: expected %0d, got %0d", want.qx, rsp_mon.qx);
                  errs++;
               end
               if (rsp_mon.qy !== want.qy) begin
                  $error("qy: expected %0d, got %0d", want.qy, rsp_mon.qy);
                  errs++;
               end
               if (rsp_mon.qz !== want.qz) begin
                  $error("qz: expected %0d, got %0d", want.qz, rsp_mon.qz);
                  errs++;
               end
               if (rsp_mon.region !== want.region) begin
                  $error("region: expected %0d, got %0d", want.region, rsp_mon.region);
                  errs++;
               end
               if (rsp_mon.degenerate !== want.degenerate) begin
                  $error("degenerate: expected %0d, got %0d", want.degenerate,
                         rsp_mon.degenerate);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
   end

endmodule

>>> test/closest_point_on_triangle_core_test.sv
// Testbench top that streams triangle queries into the core and reports the verdict.
`timescale 1ns / 100ps

module closest_point_on_triangle_core_test;
   import cpt_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
   localparam int        ONE  = 256;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   accepted;
   int   cycle_count;

   cpt_req_if req_bus ();
   cpt_rsp_if rsp_bus ();

   closest_point_on_triangle_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   closest_point_on_triangle_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic send_query(input coord_type c[12]);
      req_bus.valid    <= 1'b1;
      req_bus.ax       <= c[0];
      req_bus.ay       <= c[1];
      req_bus.az       <= c[2];
      req_bus.bx       <= c[3];
      req_bus.by_coord <= c[4];
      req_bus.bz       <= c[5];
      req_bus.cx       <= c[6];
      req_bus.cy       <= c[7];
      req_bus.cz       <= c[8];
      req_bus.px       <= c[9];
      req_bus.py       <= c[10];
      req_bus.pz       <= c[11];
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      accepted++;
   endtask

   task automatic pause_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic coord_type pick_coord(input int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic void random_query(output coord_type c[12]);
      int span;
      int mode;
      int k;
      mode = $urandom_range(0, 9);
      span = (mode < 2) ? 0 : (mode < 5) ? 64 * ONE : 8 * ONE;
      for (int i = 0; i < 12; i++) c[i] = pick_coord(span);
      if (mode == 5) begin
         k = $urandom_range(0, 4) - 2;
         for (int i = 0; i < 3; i++) c[6 + i] = c[i] + k * (c[3 + i] - c[i]);
      end else if (mode == 6) begin
         for (int i = 0; i < 3; i++) c[3 * $urandom_range(1, 2) + i] = c[i];
      end else if (mode == 7) begin
         for (int i = 0; i < 3; i++) c[9 + i] = c[3 * $urandom_range(0, 2) + i] + pick_coord(4);
      end else if (mode == 8) begin
         for (int i = 0; i < 3; i++) c[9 + i] = (c[i] + c[3 + i] + c[6 + i]) / 3 + pick_coord(ONE);
      end
   endfunction

   initial begin
      coord_type c[12];
      reset         = 1'b1;
      accepted      = 0;
      req_bus.valid = 1'b0;
      {req_bus.ax, req_bus.ay, req_bus.az, req_bus.bx, req_bus.by_coord, req_bus.bz,
       req_bus.cx, req_bus.cy, req_bus.cz, req_bus.px, req_bus.py, req_bus.pz} = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      c = '{default: coord_type'(0)};
      send_query(c);
      c = '{default: CMAX};
      send_query(c);
      c = '{default: CMIN};
      send_query(c);
      c = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN};
      send_query(c);
      c = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX};
      send_query(c);
      c = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, -ONE, -ONE, 0};
      send_query(c);
      c = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, 6*ONE, -ONE, ONE};
      send_query(c);
      c = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, 2*ONE, -ONE, 0};
      send_query(c);
      c = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, -ONE, 6*ONE, 0};
      send_query(c);
      c = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, -ONE, 2*ONE, 0};
      send_query(c);
      c = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, 3*ONE, 3*ONE, -ONE};
      send_query(c);
      c = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, ONE, ONE, 5*ONE};
      send_query(c);
      c = '{ONE, 0, 0, ONE, 0, 0, 3*ONE, 0, 0, ONE + 3, 2*ONE, 0};
      send_query(c);
      c = '{ONE, 0, 0, 0, 0, 0, 2*ONE, 0, 0, ONE + 128, ONE, 0};
      send_query(c);
      c = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, CMAX, CMIN, 7};
      send_query(c);
      c = '{CMIN, 0, 0, CMAX, 0, 0, 0, CMAX, 0, 0, CMIN, CMAX};
      send_query(c);

      pause_sender(3);
      while (pending_count != 0) @(posedge clock);

      for (int n = 0; n < 2000; ) begin
         int burst;
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst && n < 2000; j++, n++) begin
            random_query(c);
            send_query(c);
         end
         if (n > 1000 && n < 1050) begin
            pause_sender(1);
            while (pending_count != 0) @(posedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 12));
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      while (1) begin
         @(posedge clock);
         if (accepted >= 400 && accepted < 420) begin
            rsp_bus.ready <= 1'b0;
            hold = 300;
            while (hold > 0) begin
               @(posedge clock);
               hold--;
            end
            rsp_bus.ready <= 1'b1;
            while (accepted < 420) @(posedge clock);
         end else if ((cycle_count / 500) % 3 == 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 9) < 7);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < 400000) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule
